>>> rtl/arc_pkg.sv
// Shared types and constants for the address resolution cache.
// Used by arc_table, arc_ctrl and address_resolution_cache; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package arc_pkg;

  // default table depth
  localparam int EntriesDef = 32;

  // field widths
  localparam int IpW     = 32;
  localparam int MacW    = 48;
  localparam int StatusW = 2;

  // command codes carried on the input tuser
  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  // result status codes carried on the output tuser
  typedef enum logic [StatusW-1:0] {
    ST_HIT    = 2'd0,
    ST_MISS   = 2'd1,
    ST_INSERT = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  // one stored table entry, ip in the low bits
  typedef struct packed {
    logic [MacW-1:0] mac;
    logic [IpW-1:0]  ip;
  } entry_t;

  // memory port controls from the sequencer
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

`default_nettype wire

>>> rtl/arc_table.sv
// Entry memory of the address resolution cache: one write port, one
// registered read port. Depends on arc_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none

module arc_table #(
  parameter int Entries = arc_pkg::EntriesDef,
  parameter int AddrW   = (Entries > 1) ? $clog2(Entries) : 1
) (
  input  wire logic                 clk_i,
  input  wire arc_pkg::mem_ctl_t    mem_ctl_i,
  input  wire logic [AddrW-1:0]     wr_addr_i,
  input  wire arc_pkg::entry_t      wr_data_i,
  input  wire logic [AddrW-1:0]     rd_addr_i,
  output arc_pkg::entry_t           rd_data_o
);

  arc_pkg::entry_t mem_q [Entries];
  arc_pkg::entry_t rd_data_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (mem_ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (mem_ctl_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

>>> rtl/arc_ctrl.sv
// Sequencer of the address resolution cache: fill count, insert, lookup scan
// over the entry memory and the output register. Depends on arc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module arc_ctrl #(
  parameter int Entries = arc_pkg::EntriesDef,
  parameter int AddrW   = (Entries > 1) ? $clog2(Entries) : 1,
  parameter int CountW  = $clog2(Entries + 1)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // input items
  input  wire logic                        s_valid_i,
  output logic                             s_ready_o,
  input  wire logic                        s_cmd_i,
  input  wire arc_pkg::entry_t             s_entry_i,
  // result items
  output logic                             m_valid_o,
  input  wire logic                        m_ready_i,
  output arc_pkg::status_e                 m_status_o,
  output logic [arc_pkg::MacW-1:0]         m_mac_o,
  // entry memory
  output arc_pkg::mem_ctl_t                mem_ctl_o,
  output logic [AddrW-1:0]                 wr_addr_o,
  output arc_pkg::entry_t                  wr_data_o,
  output logic [AddrW-1:0]                 rd_addr_o,
  input  wire arc_pkg::entry_t             rd_data_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  state_e                     state_q, state_d;
  logic [CountW-1:0]          count_q, count_d;
  logic [AddrW-1:0]           idx_q, idx_d;
  logic [arc_pkg::IpW-1:0]    key_q, key_d;
  arc_pkg::status_e           res_status_q, res_status_d;
  logic [arc_pkg::MacW-1:0]   res_mac_q, res_mac_d;
  logic                       out_valid_q, out_valid_d;
  arc_pkg::status_e           out_status_q, out_status_d;
  logic [arc_pkg::MacW-1:0]   out_mac_q, out_mac_d;

  logic [AddrW-1:0]           idx_next;
  logic                       scan_last;

  assign idx_next  = AddrW'(idx_q + 1'b1);
  assign scan_last = (CountW'(idx_q) + CountW'(1)) == count_q;

  // entries fill from index 0 upward and are never freed, so the fill count
  // is both the next free slot and the bound of valid entries
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    key_d        = key_q;
    res_status_d = res_status_q;
    res_mac_d    = res_mac_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_mac_d    = out_mac_q;
    mem_ctl_o    = '0;
    wr_addr_o    = count_q[AddrW-1:0];
    wr_data_o    = s_entry_i;
    rd_addr_o    = '0;

    // output register drains
    if (out_valid_q && m_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          key_d     = s_entry_i.ip;
          res_mac_d = '0;
          if (s_cmd_i == arc_pkg::CMD_INSERT) begin
            if (count_q != CountW'(Entries)) begin
              mem_ctl_o.wr_en = 1'b1;
              count_d         = CountW'(count_q + 1'b1);
              res_status_d    = arc_pkg::ST_INSERT;
            end else begin
              res_status_d    = arc_pkg::ST_FULL;
            end
            state_d = S_DONE;
          end else if (count_q == '0) begin
            res_status_d = arc_pkg::ST_MISS;
            state_d      = S_DONE;
          end else begin
            mem_ctl_o.rd_en = 1'b1;
            rd_addr_o       = '0;
            idx_d           = '0;
            state_d         = S_SCAN;
          end
        end
      end
      // compare one entry per cycle, lowest index first
      S_SCAN: begin
        if (rd_data_i.ip == key_q) begin
          res_status_d = arc_pkg::ST_HIT;
          res_mac_d    = rd_data_i.mac;
          state_d      = S_DONE;
        end else if (scan_last) begin
          res_status_d = arc_pkg::ST_MISS;
          state_d      = S_DONE;
        end else begin
          mem_ctl_o.rd_en = 1'b1;
          rd_addr_o       = idx_next;
          idx_d           = idx_next;
        end
      end
      // hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_q || m_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_mac_d    = res_mac_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      idx_q        <= '0;
      key_q        <= '0;
      res_status_q <= arc_pkg::ST_MISS;
      res_mac_q    <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= arc_pkg::ST_MISS;
      out_mac_q    <= '0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      idx_q        <= idx_d;
      key_q        <= key_d;
      res_status_q <= res_status_d;
      res_mac_q    <= res_mac_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_mac_q    <= out_mac_d;
    end
  end

  assign s_ready_o  = (state_q == S_IDLE);
  assign m_valid_o  = out_valid_q;
  assign m_status_o = out_status_q;
  assign m_mac_o    = out_mac_q;

endmodule

`default_nettype wire

>>> rtl/address_resolution_cache.sv
// Fully associative IPv4 to MAC address table, top level.
// Depends on arc_pkg, arc_table and arc_ctrl.
//
// Each input item is an insert or a lookup and yields one result item. An
// insert stores the pair in the next free entry (entries fill from index 0
// and are only cleared by reset, no duplicate check) or reports the table
// full. A lookup scans the stored entries from index 0 through a single
// memory read port, one entry per cycle, and returns the MAC of the first
// match or a miss. An insert, or a lookup on an empty table, goes from
// idle straight to the done state; a lookup stays in the scan state until
// it hits or has compared all n stored entries, at most Entries of them.
// A finished result sits in an output register, and the next item is taken
// while it waits. Reset takes effect at once: no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module address_resolution_cache #(
  parameter int Entries = arc_pkg::EntriesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input items
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [79:0] s_axis_tdata,   // ip_address [31:0], mac_address [79:32]
  input  wire logic        s_axis_tuser,   // command [0]
  // result items
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // mac_found [47:0]
  output logic [1:0]       m_axis_tuser    // status [1:0]
);

  localparam int AddrW  = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int CountW = $clog2(Entries + 1);

  arc_pkg::entry_t   s_entry;
  arc_pkg::mem_ctl_t mem_ctl;
  arc_pkg::entry_t   wr_data;
  arc_pkg::entry_t   rd_data;
  arc_pkg::status_e  m_status;
  logic [AddrW-1:0]  wr_addr;
  logic [AddrW-1:0]  rd_addr;

  // unpack the input item
  assign s_entry.ip  = s_axis_tdata[31:0];
  assign s_entry.mac = s_axis_tdata[79:32];

  arc_ctrl #(
    .Entries (Entries),
    .AddrW   (AddrW),
    .CountW  (CountW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_o  (s_axis_tready),
    .s_cmd_i    (s_axis_tuser),
    .s_entry_i  (s_entry),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_status_o (m_status),
    .m_mac_o    (m_axis_tdata),
    .mem_ctl_o  (mem_ctl),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data)
  );

  arc_table #(
    .Entries (Entries),
    .AddrW   (AddrW)
  ) u_table (
    .clk_i     (clk_i),
    .mem_ctl_i (mem_ctl),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign m_axis_tuser = m_status;

endmodule

`default_nettype wire
